>>> design/pxc_pkg.sv
// shared constants, codes and types of the page xor chain cipher
package pxc_pkg;

  localparam int KEY_BYTES = 64;
  localparam int KEY_AW    = $clog2(KEY_BYTES);
  localparam int MAX_PAGE  = 4096;

  localparam int PAGE_W = 17;
  localparam int POS_W  = 16;
  localparam int LEN_W  = 7;
  localparam int BYTE_W = 8;
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;
  localparam int STEP_W = $clog2(KEY_AW + 1);

  typedef logic [1:0] opcode_t;
  localparam opcode_t OPC_PAGE    = 2'd0;
  localparam opcode_t OPC_LOAD_RD = 2'd1;
  localparam opcode_t OPC_LOAD_WR = 2'd2;

  typedef logic [1:0] dir_t;
  localparam dir_t DIR_PASS = 2'd0;
  localparam dir_t DIR_DEC  = 2'd1;
  localparam dir_t DIR_ENC  = 2'd2;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_PAGE_SIZE  = 3'd0;
  localparam reg_idx_t REG_RD_KEY_LEN = 3'd1;
  localparam reg_idx_t REG_WR_KEY_LEN = 3'd2;
  localparam reg_idx_t REG_DEC_OFF    = 3'd3;
  localparam reg_idx_t REG_ENC_OFF    = 3'd4;

  typedef enum logic [1:0] {
    MODE_COPY,
    MODE_DEC,
    MODE_ENC
  } mode_t;

  // per page byte: advance the repeat index and read the key store
  typedef struct packed {
    logic              adv;
    logic [KEY_AW-1:0] pos;
    logic [KEY_AW-1:0] pos_nxt;
    logic [KEY_AW-1:0] pos_cur;
  } key_step_t;

  typedef struct packed {
    logic busy;
    logic zero;
  } key_stat_t;

endpackage

>>> design/pxc_ram.sv
// generic single write port, single read port ram with registered read
module pxc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/pxc_key_unit.sv
// key store with padded key index tracking and remainder recompute
module pxc_key_unit
  import pxc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [LEN_W-1:0]  len,
  input  logic              len_wr,
  input  logic              key_we,
  input  logic [KEY_AW-1:0] key_waddr,
  input  logic [BYTE_W-1:0] key_wdata,
  input  key_step_t         step,
  output key_stat_t         stat,
  output logic [BYTE_W-1:0] key_rdata
);

  logic [KEY_AW-1:0] cnt_r, cnt_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [KEY_AW-1:0] div_d_r, div_d_nxt;
  logic [KEY_AW-1:0] rem_r, rem_nxt;
  logic [KEY_AW:0]   rem_sh;
  logic [KEY_AW:0]   rem_sub;
  logic              padded;
  logic              below_len;
  logic [KEY_AW-1:0] raddr;
  logic [LEN_W:0]    len_p1;
  logic [LEN_W:0]    cnt_p1;

  assign padded    = (len != '0) && ({1'b0, len} < (LEN_W+1)'(KEY_BYTES));
  assign below_len = {{(LEN_W-KEY_AW){1'b0}}, step.pos} < len;
  assign stat.zero = padded && ({{(LEN_W-KEY_AW){1'b0}}, step.pos} == len);
  assign stat.busy = (step_r != '0);
  assign raddr     = (!padded || below_len) ? step.pos : cnt_r;

  assign len_p1 = {1'b0, len} + (LEN_W+1)'(1);
  assign cnt_p1 = (LEN_W+1)'(cnt_r) + (LEN_W+1)'(1);

  // bit-serial remainder: (pos - 1) mod len, one dividend bit per cycle
  assign rem_sh  = {rem_r, div_d_r[KEY_AW-1]};
  assign rem_sub = rem_sh - len[KEY_AW:0];

  always_comb begin
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    div_d_nxt = div_d_r;
    rem_nxt   = rem_r;
    if (len_wr) begin
      step_nxt  = STEP_W'(KEY_AW);
      // start from the held position, which a lowered page size only hides
      div_d_nxt = step.pos_cur - KEY_AW'(1);
      rem_nxt   = '0;
    end else if (stat.busy) begin
      step_nxt  = step_r - STEP_W'(1);
      div_d_nxt = div_d_r << 1;
      rem_nxt   = (rem_sh >= {1'b0, len[KEY_AW-1:0]} || len[LEN_W-1]) ?
                  rem_sub[KEY_AW-1:0] : rem_sh[KEY_AW-1:0];
      if (step_r == STEP_W'(1)) begin
        cnt_nxt = rem_nxt;
      end
    end else if (step.adv) begin
      if ((LEN_W+1)'(step.pos_nxt) == len_p1) begin
        cnt_nxt = '0;
      end else if (cnt_p1 == {1'b0, len}) begin
        cnt_nxt = '0;
      end else begin
        cnt_nxt = cnt_p1[KEY_AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      step_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_d_r <= div_d_nxt;
    rem_r   <= rem_nxt;
  end

  pxc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (KEY_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .re    (step.adv),
    .raddr (raddr),
    .rdata (key_rdata)
  );

endmodule

>>> design/page_xor_chain_cipher.sv
// page xor chain cipher top level: register port, byte pipeline, key stores
//
// One item per clock cycle, sustained while no key index recompute is under
// way and the output is not stalled. A page byte reads its key byte from a
// 64 x 8 key ram with a registered read, then the chain add or subtract and
// the output register follow. Key load items write the key ram at accept and
// give no result. A write to a key length register holds off input while the
// key repeat index is recomputed by a bit-serial remainder unit (one bit per
// cycle). Key stores are not cleared after reset.
module page_xor_chain_cipher
  import pxc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_opcode,
  input  logic [5:0]        in_key_index,
  input  logic [7:0]        in_data_byte,
  input  logic [1:0]        in_direction,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_result_byte,
  output logic              out_last_of_page,
  output logic              out_passed_through
);

  // configuration registers
  logic [PAGE_W-1:0] page_size_r;
  logic [LEN_W-1:0]  rd_len_r, wr_len_r;
  logic              dec_off_r, enc_off_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_size_r <= '0;
      rd_len_r    <= LEN_W'(KEY_BYTES);
      wr_len_r    <= LEN_W'(KEY_BYTES);
      dec_off_r   <= 1'b0;
      enc_off_r   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PAGE_SIZE:  page_size_r <= pwdata[PAGE_W-1:0];
        REG_RD_KEY_LEN: rd_len_r    <= pwdata[LEN_W-1:0];
        REG_WR_KEY_LEN: wr_len_r    <= pwdata[LEN_W-1:0];
        REG_DEC_OFF:    dec_off_r   <= pwdata[0];
        REG_ENC_OFF:    enc_off_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PAGE_SIZE:  prdata = APB_DW'(page_size_r);
      REG_RD_KEY_LEN: prdata = APB_DW'(rd_len_r);
      REG_WR_KEY_LEN: prdata = APB_DW'(wr_len_r);
      REG_DEC_OFF:    prdata = APB_DW'(dec_off_r);
      REG_ENC_OFF:    prdata = APB_DW'(enc_off_r);
      default:        prdata = '0;
    endcase
  end

  // stage 0: accept, page position, key read
  logic              out_free;
  logic              s1_v_r, s1_v_nxt;
  logic              acc, acc_page;
  logic              bypass;
  logic [POS_W-1:0]  pos_r, pos_nxt, eff_pos;
  logic [PAGE_W-1:0] pos_inc;
  logic              at_last;
  mode_t             mode;
  key_step_t         step;
  key_stat_t         rd_stat, wr_stat;
  logic [BYTE_W-1:0] rd_key, wr_key;

  assign out_free = !out_valid || out_ready;
  assign in_ready = !rd_stat.busy && !wr_stat.busy && (!s1_v_r || out_free);
  assign acc      = in_valid && in_ready;
  assign acc_page = acc && (in_opcode == OPC_PAGE);

  assign bypass  = (page_size_r == '0) || (page_size_r > PAGE_W'(MAX_PAGE));
  // a position left beyond a lowered page size starts a new page
  assign eff_pos = ({1'b0, pos_r} >= page_size_r) ? '0 : pos_r;
  assign pos_inc = {1'b0, eff_pos} + PAGE_W'(1);
  assign at_last = pos_inc >= page_size_r;
  assign pos_nxt = at_last ? '0 : pos_inc[POS_W-1:0];

  always_comb begin
    if (bypass) begin
      mode = MODE_COPY;
    end else if (in_direction == DIR_DEC && !dec_off_r) begin
      mode = MODE_DEC;
    end else if (in_direction == DIR_ENC && !enc_off_r) begin
      mode = MODE_ENC;
    end else begin
      mode = MODE_COPY;
    end
  end

  assign step.adv     = acc_page && !bypass;
  assign step.pos     = eff_pos[KEY_AW-1:0];
  assign step.pos_nxt = pos_nxt[KEY_AW-1:0];
  assign step.pos_cur = pos_r[KEY_AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (step.adv) begin
      pos_r <= pos_nxt;
    end
  end

  pxc_key_unit u_rd_key (
    .clk       (clk),
    .rst_n     (rst_n),
    .len       (rd_len_r),
    .len_wr    (cfg_wr && cfg_idx == REG_RD_KEY_LEN),
    .key_we    (acc && in_opcode == OPC_LOAD_RD),
    .key_waddr (in_key_index[KEY_AW-1:0]),
    .key_wdata (in_data_byte),
    .step      (step),
    .stat      (rd_stat),
    .key_rdata (rd_key)
  );

  pxc_key_unit u_wr_key (
    .clk       (clk),
    .rst_n     (rst_n),
    .len       (wr_len_r),
    .len_wr    (cfg_wr && cfg_idx == REG_WR_KEY_LEN),
    .key_we    (acc && in_opcode == OPC_LOAD_WR),
    .key_waddr (in_key_index[KEY_AW-1:0]),
    .key_wdata (in_data_byte),
    .step      (step),
    .stat      (wr_stat),
    .key_rdata (wr_key)
  );

  // stage 1: chain arithmetic
  mode_t             s1_mode_r;
  logic              s1_first_r, s1_last_r, s1_kz_r;
  logic [BYTE_W-1:0] s1_data_r;
  logic [BYTE_W-1:0] chain_r, chain_nxt;
  logic [BYTE_W-1:0] key_byte, prev, res;
  logic              s1_move;

  assign s1_v_nxt = acc_page ? 1'b1 : (out_free ? 1'b0 : s1_v_r);
  assign s1_move  = s1_v_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_page) begin
      s1_mode_r  <= mode;
      s1_first_r <= !bypass && (eff_pos == '0);
      s1_last_r  <= !bypass && at_last;
      s1_kz_r    <= (mode == MODE_DEC) ? rd_stat.zero : wr_stat.zero;
      s1_data_r  <= in_data_byte;
    end
  end

  assign key_byte = s1_kz_r ? '0 : ((s1_mode_r == MODE_DEC) ? rd_key : wr_key);
  assign prev     = s1_first_r ? '0 : chain_r;

  always_comb begin
    case (s1_mode_r)
      MODE_DEC: begin
        res       = (s1_data_r - prev) ^ key_byte;
        chain_nxt = s1_data_r;
      end
      MODE_ENC: begin
        res       = (s1_data_r ^ key_byte) + prev;
        chain_nxt = res;
      end
      default: begin
        res       = s1_data_r;
        chain_nxt = s1_first_r ? '0 : chain_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
    end else if (s1_move) begin
      chain_r <= chain_nxt;
    end
  end

  // output register
  logic out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_result_byte    <= res;
      out_last_of_page   <= s1_last_r;
      out_passed_through <= (s1_mode_r == MODE_COPY);
    end
  end

  assign out_valid = out_v_r;

endmodule

>>> design/pxc_checker.sv
// port-level checks of the page xor chain cipher, bound to the top level
module pxc_checker
  import pxc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [APB_AW-1:0] paddr,
  input logic [APB_DW-1:0] pwdata,
  input logic [APB_DW-1:0] prdata,
  input logic              pready,
  input logic              in_valid,
  input logic              in_ready,
  input logic [1:0]        in_opcode,
  input logic [5:0]        in_key_index,
  input logic [7:0]        in_data_byte,
  input logic [1:0]        in_direction,
  input logic              out_valid,
  input logic              out_ready,
  input logic [7:0]        out_result_byte,
  input logic              out_last_of_page,
  input logic              out_passed_through
);

  // no result may survive reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_byte) &&
      $stable(out_last_of_page) && $stable(out_passed_through))
    else $error("stalled result changed");

  // out_valid must follow every accepted page byte
  a_page_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == OPC_PAGE |-> ##2 out_valid)
    else $error("page byte gave no result");

  // a key length write holds off input while the repeat index is rebuilt
  a_len_busy: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready &&
      (paddr[APB_AW-1:2] == REG_RD_KEY_LEN || paddr[APB_AW-1:2] == REG_WR_KEY_LEN)
      |=> !in_ready)
    else $error("input taken during key index recompute");

endmodule

bind page_xor_chain_cipher pxc_checker u_pxc_checker (.*);

>>> dv/tb.sv
// self-checking testbench for the page xor chain cipher
`timescale 1ns / 100ps

module tb;
  import pxc_pkg::*;

  localparam opcode_t OPC_NONE = 2'd3;
  localparam dir_t DIR_RSVD = 2'd3;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 4;
  localparam int ROUNDS_PER_PHASE = 6;
  localparam int BYTES_PER_ROUND = 58;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       copied;
  } page_out_t;

  logic clk;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_opcode = '0;
  logic [5:0] in_key_index = '0;
  logic [7:0] in_data_byte = '0;
  logic [1:0] in_direction = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_result_byte;
  logic out_last_of_page;
  logic out_passed_through;

  page_xor_chain_cipher dut (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_opcode(in_opcode),
    .in_key_index(in_key_index),
    .in_data_byte(in_data_byte),
    .in_direction(in_direction),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_result_byte(out_result_byte),
    .out_last_of_page(out_last_of_page),
    .out_passed_through(out_passed_through)
  );

  // predictor state, mirrors the block after reset
  logic [PAGE_W-1:0] cfg_page = '0;
  logic [LEN_W-1:0] cfg_rd_len = 7'd64;
  logic [LEN_W-1:0] cfg_wr_len = 7'd64;
  logic cfg_dec_off = 1'b0;
  logic cfg_enc_off = 1'b0;
  logic [7:0] rd_key [KEY_BYTES];
  logic [7:0] wr_key [KEY_BYTES];
  logic [7:0] chain = '0;
  int unsigned page_pos = 0;

  page_out_t pending_out[$];

  int errors = 0;
  int items_sent = 0;
  int bytes_checked = 0;
  int settings_used = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic logic [7:0] padded_key_byte(logic is_rd, logic [LEN_W-1:0] len,
                                                int unsigned pos);
    int unsigned p;
    int unsigned raw;
    p = pos % KEY_BYTES;
    if (len == 0 || len >= KEY_BYTES || p < len) begin
      raw = p;
    end else if (p == len) begin
      return 8'h00;
    end else begin
      raw = (p - 1) % len;
    end
    return is_rd ? rd_key[raw] : wr_key[raw];
  endfunction

  // advances the cipher state by one accepted item
  task automatic cipher_step(opcode_t op, logic [5:0] idx, logic [7:0] data, dir_t dir);
    page_out_t r;
    logic [7:0] prev;
    logic [7:0] k;
    r.value = data;
    r.last = 1'b0;
    r.copied = 1'b1;
    if (op == OPC_LOAD_RD) begin
      rd_key[idx] = data;
    end else if (op == OPC_LOAD_WR) begin
      wr_key[idx] = data;
    end else if (op == OPC_PAGE) begin
      if (cfg_page != 0 && cfg_page <= MAX_PAGE) begin
        if (page_pos >= cfg_page) page_pos = 0;
        prev = (page_pos == 0) ? 8'h00 : chain;
        if (dir == DIR_DEC && !cfg_dec_off) begin
          k = padded_key_byte(1'b1, cfg_rd_len, page_pos);
          r.value = (data - prev) ^ k;
          chain = data;
          r.copied = 1'b0;
        end else if (dir == DIR_ENC && !cfg_enc_off) begin
          k = padded_key_byte(1'b0, cfg_wr_len, page_pos);
          r.value = (data ^ k) + prev;
          chain = r.value;
          r.copied = 1'b0;
        end else if (page_pos == 0) begin
          chain = 8'h00;
        end
        if (page_pos + 1 >= cfg_page) begin
          r.last = 1'b1;
          page_pos = 0;
        end else begin
          page_pos++;
        end
      end
      pending_out.push_back(r);
    end
  endtask

  // prediction on accepted items and register writes, checking on results
  always @(posedge clk) begin
    page_out_t want;
    if (rst_n) begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[APB_AW-1:2]))
          REG_PAGE_SIZE:  cfg_page = pwdata[PAGE_W-1:0];
          REG_RD_KEY_LEN: cfg_rd_len = pwdata[LEN_W-1:0];
          REG_WR_KEY_LEN: cfg_wr_len = pwdata[LEN_W-1:0];
          REG_DEC_OFF:    cfg_dec_off = pwdata[0];
          REG_ENC_OFF:    cfg_enc_off = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        cipher_step(opcode_t'(in_opcode), in_key_index, in_data_byte, dir_t'(in_direction));
      if (out_valid === 1'b1 && out_ready) begin
        if (pending_out.size() == 0) begin
          report_mismatch("unexpected result byte", out_result_byte, 0);
        end else begin
          want = pending_out.pop_front();
          bytes_checked++;
          if (out_result_byte !== want.value)
            report_mismatch("result_byte", out_result_byte, want.value);
          if (out_last_of_page !== want.last)
            report_mismatch("last_of_page", out_last_of_page, want.last);
          if (out_passed_through !== want.copied)
            report_mismatch("passed_through", out_passed_through, want.copied);
        end
      end
    end
  end

  // receiver: random stalls, or a counted hold-off when requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  // watchdog: ends the run when nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid === 1'b1 && out_ready) || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no handshake for %0d cycles, %0d results outstanding",
             STALL_LIMIT, pending_out.size());
    $display("Simulation FAILED");
    $finish;
  end

  // valid stays high into the next item unless the sender idles
  task automatic send_item(opcode_t op, logic [5:0] idx, logic [7:0] data, dir_t dir);
    @(negedge clk);
    while (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_key_index <= idx;
    in_data_byte <= data;
    in_direction <= dir;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // park the input and let every expected byte come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    // key loads leave nothing to wait for, so give the pipe time to empty
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [APB_DW-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(int unsigned psize, int unsigned rlen, int unsigned wlen,
                            logic doff, logic eoff);
    cfg_write(REG_PAGE_SIZE, psize);
    cfg_write(REG_RD_KEY_LEN, rlen);
    cfg_write(REG_WR_KEY_LEN, wlen);
    cfg_write(REG_DEC_OFF, APB_DW'(doff));
    cfg_write(REG_ENC_OFF, APB_DW'(eoff));
    settings_used++;
  endtask

  function automatic dir_t pick_dir();
    int r;
    r = $urandom_range(99);
    if (r < 45) return DIR_DEC;
    if (r < 90) return DIR_ENC;
    if (r < 97) return DIR_PASS;
    return DIR_RSVD;
  endfunction

  function automatic int unsigned pick_key_len();
    case ($urandom_range(7))
      0: return 1;
      1: return 64;
      2: return 0;
      3: return 63;
      4: return $urandom_range(127, 65);
      default: return $urandom_range(63, 1);
    endcase
  endfunction

  function automatic int unsigned pick_page_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(130, 2);
    if (r < 76) return 1;
    if (r < 82) return 0;
    if (r < 87) return MAX_PAGE;
    if (r < 90) return (1 << PAGE_W) - 1;
    if (r < 95) return $urandom_range((1 << PAGE_W) - 2, MAX_PAGE + 1);
    return $urandom_range(MAX_PAGE - 1, 131);
  endfunction

  // fills both key stores so no unwritten entry is ever read
  task automatic test_key_load();
    for (int i = 0; i < KEY_BYTES; i++) begin
      send_item(OPC_LOAD_RD, 6'(i),
                (i == 0) ? 8'h00 : (i == KEY_BYTES - 1) ? 8'hff : 8'($urandom),
                dir_t'($urandom_range(3)));
      send_item(OPC_LOAD_WR, 6'(i),
                (i == 0) ? 8'hff : (i == KEY_BYTES - 1) ? 8'h00 : 8'($urandom),
                dir_t'($urandom_range(3)));
    end
    wait_idle();
  endtask

  task automatic test_directed_bytes();
    set_config(6, 64, 64, 1'b0, 1'b0);
    send_item(OPC_PAGE, 6'd0, 8'h00, DIR_ENC);
    send_item(OPC_PAGE, 6'd63, 8'hff, DIR_ENC);
    send_item(OPC_PAGE, 6'd0, 8'h5a, DIR_ENC);
    send_item(OPC_PAGE, 6'd63, 8'ha5, DIR_ENC);
    send_item(OPC_PAGE, 6'd0, 8'hff, DIR_ENC);
    send_item(OPC_PAGE, 6'd0, 8'h01, DIR_ENC);
    send_item(OPC_PAGE, 6'd63, 8'hff, DIR_DEC);
    send_item(OPC_PAGE, 6'd0, 8'h00, DIR_DEC);
    send_item(OPC_PAGE, 6'd0, 8'h80, DIR_DEC);
    send_item(OPC_PAGE, 6'd0, 8'h7f, DIR_DEC);
    send_item(OPC_PAGE, 6'd0, 8'hff, DIR_DEC);
    send_item(OPC_PAGE, 6'd0, 8'h00, DIR_DEC);
    // mixed page: pass, reserved direction and an ignored opcode in the middle
    send_item(OPC_PAGE, 6'd0, 8'h11, DIR_PASS);
    send_item(OPC_PAGE, 6'd0, 8'h22, DIR_RSVD);
    send_item(OPC_NONE, 6'd63, 8'hff, DIR_RSVD);
    send_item(OPC_PAGE, 6'd0, 8'h33, DIR_ENC);
    send_item(OPC_PAGE, 6'd0, 8'h44, DIR_DEC);
    send_item(OPC_PAGE, 6'd0, 8'h55, DIR_PASS);
    send_item(OPC_PAGE, 6'd0, 8'h66, DIR_ENC);
    wait_idle();
    // off flags copy the byte but keep the page position moving
    set_config(6, 64, 64, 1'b1, 1'b1);
    send_item(OPC_PAGE, 6'd0, 8'h9c, DIR_ENC);
    send_item(OPC_PAGE, 6'd0, 8'h9d, DIR_DEC);
    wait_idle();
    // bypass page sizes: zero, just above the maximum, all ones
    set_config(0, 1, 1, 1'b0, 1'b0);
    send_item(OPC_PAGE, 6'd0, 8'hc3, DIR_ENC);
    wait_idle();
    cfg_write(REG_PAGE_SIZE, MAX_PAGE + 1);
    send_item(OPC_PAGE, 6'd0, 8'h3c, DIR_DEC);
    wait_idle();
    cfg_write(REG_PAGE_SIZE, (1 << PAGE_W) - 1);
    send_item(OPC_PAGE, 6'd0, 8'he7, DIR_ENC);
    wait_idle();
  endtask

  // page size lowered below the current position restarts the page
  task automatic test_page_shrink();
    set_config(MAX_PAGE, 5, 9, 1'b0, 1'b0);
    for (int i = 0; i < 20; i++) send_item(OPC_PAGE, 6'($urandom), 8'($urandom), DIR_ENC);
    wait_idle();
    cfg_write(REG_PAGE_SIZE, 10);
    for (int i = 0; i < 15; i++) send_item(OPC_PAGE, 6'($urandom), 8'($urandom), DIR_DEC);
    wait_idle();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    set_config(16, 7, 64, 1'b0, 1'b0);
    hold_left = 300;
    for (int i = 0; i < 60; i++)
      send_item(OPC_PAGE, 6'($urandom), 8'($urandom), (i < 32) ? DIR_ENC : DIR_DEC);
    wait_idle();
  endtask

  task automatic random_round(int n_bytes);
    int sent;
    int in_page;
    int r;
    dir_t pdir;
    sent = 0;
    in_page = 0;
    pdir = pick_dir();
    while (sent < n_bytes) begin
      r = $urandom_range(99);
      if (r < 4) begin
        // rekey one entry mid-stream
        send_item(($urandom_range(1)) ? OPC_LOAD_RD : OPC_LOAD_WR, 6'($urandom),
                  8'($urandom), dir_t'($urandom_range(3)));
      end else if (r < 6) begin
        send_item(OPC_NONE, 6'($urandom), 8'($urandom), dir_t'($urandom_range(3)));
      end else begin
        send_item(OPC_PAGE, 6'($urandom), 8'($urandom),
                  (r < 11) ? dir_t'($urandom_range(3)) : pdir);
        sent++;
        if (cfg_page != 0 && cfg_page <= MAX_PAGE && ++in_page >= cfg_page) begin
          in_page = 0;
          pdir = pick_dir();
        end
      end
    end
  endtask

  task automatic test_random_traffic();
    int idle_set [4] = '{0, 76, 0, 36};
    int stall_set [4] = '{0, 0, 76, 36};
    for (int ph = 0; ph < 4; ph++) begin
      snd_idle_pct = idle_set[ph];
      rcv_stall_pct = stall_set[ph];
      for (int rnd = 0; rnd < ROUNDS_PER_PHASE; rnd++) begin
        set_config(pick_page_size(), pick_key_len(), pick_key_len(),
                   ($urandom_range(99) < 20), ($urandom_range(99) < 20));
        random_round(BYTES_PER_ROUND);
        wait_idle();
      end
    end
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_key_load();
    test_directed_bytes();
    test_page_shrink();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (10) @(posedge clk);
    $display("sent %0d items across %0d register settings, checked %0d page bytes",
             items_sent, settings_used, bytes_checked);
    $display("covered encode, decode, pass, bypass sizes, short keys, stalls and hold-off");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
